// ----- src/mlac_pkg.sv -----
`timescale 1ns / 1ps

package mlac_pkg;

    localparam int NUM_GROUPS       = 16;
    localparam int NUM_COMPARTMENTS = 32;
    localparam int MAX_DEPTH        = 8;

    // field widths fixed by the label format
    localparam int LEVEL_W   = 8;
    localparam int COMP_W    = 32;
    localparam int GROUP_W   = 16;
    localparam int GROUP_IDX_W = 4;
    localparam int TABLE_DEPTH = 16;

    localparam int LAST_GROUP_INT = (NUM_GROUPS < GROUP_W) ? NUM_GROUPS - 1 : GROUP_W - 1;
    localparam logic [GROUP_IDX_W-1:0] LAST_GROUP = GROUP_IDX_W'(LAST_GROUP_INT);

    localparam logic [GROUP_W-1:0] GROUP_MASK =
        (NUM_GROUPS >= GROUP_W) ? {GROUP_W{1'b1}} : GROUP_W'((64'd1 << NUM_GROUPS) - 64'd1);
    localparam logic [COMP_W-1:0] COMP_MASK =
        (NUM_COMPARTMENTS >= COMP_W) ? {COMP_W{1'b1}}
                                     : COMP_W'((64'd1 << NUM_COMPARTMENTS) - 64'd1);

    localparam int STEP_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_DEPTH - 1);

    typedef enum logic {
        OP_CHECK      = 1'b0,
        OP_SET_PARENT = 1'b1
    } op_t;

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } access_t;

    typedef enum logic [1:0] {
        POL_NORMAL     = 2'd0,
        POL_FULL       = 2'd1,
        POL_READ       = 2'd2,
        POL_COMP_ONLY  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic                   start;
        logic                   quick;
        logic                   quick_ok;
        logic [GROUP_W-1:0]     subj;
        logic [GROUP_W-1:0]     obj;
    } walk_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic groups_ok;
    } walk_sts_t;

    typedef struct packed {
        logic                   has_parent;
        logic [GROUP_IDX_W-1:0] parent;
    } table_entry_t;

    typedef struct packed {
        logic                   en;
        logic [GROUP_IDX_W-1:0] idx;
        table_entry_t           entry;
    } table_wr_t;

endpackage

// ----- src/mlac_if.sv -----
`timescale 1ns / 1ps

interface mlac_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  subject_level;
    logic [7:0]  object_level;
    logic [31:0] subject_compartments;
    logic [31:0] object_compartments;
    logic [15:0] subject_groups;
    logic [15:0] object_groups;
    logic        access_kind;
    logic [1:0]  policy;
    logic [3:0]  group_index;
    logic [3:0]  parent_index;
    logic        parent_valid;

    modport source (
        output valid, operation, subject_level, object_level, subject_compartments,
               object_compartments, subject_groups, object_groups, access_kind, policy,
               group_index, parent_index, parent_valid,
        input  ready
    );
    modport sink (
        input  valid, operation, subject_level, object_level, subject_compartments,
               object_compartments, subject_groups, object_groups, access_kind, policy,
               group_index, parent_index, parent_valid,
        output ready
    );
endinterface

interface mlac_rsp_if;
    logic valid;
    logic ready;
    logic granted;
    logic level_ok;
    logic compartments_ok;
    logic groups_ok;

    modport source (
        output valid, granted, level_ok, compartments_ok, groups_ok,
        input  ready
    );
    modport sink (
        input  valid, granted, level_ok, compartments_ok, groups_ok,
        output ready
    );
endinterface

// ----- src/mac_label_access_check.sv -----
`timescale 1ns / 1ps

// Label access checker. A set-parent request writes one entry of the group
// parent table and gives no result. A check request gives one result. Level
// and compartment tests are done on acceptance; the group test resolves
// directly when a simple mask test decides it (compartments-only policy,
// empty object set, empty subject set, direct group overlap). Otherwise a
// sequencer walks the parent table with one lookup and one compare per
// cycle, scanning the groups in order and walking the ancestor chain of each
// object group. A walk needs at least one group outside the object set, so
// at most 15 groups are walked; the walk ends early at the first match. The
// input is not ready while a check is in progress; a finished result sits in
// an output register so the next request can be taken while it waits.
module mac_label_access_check
    import mlac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mlac_req_if.sink    req,
    mlac_rsp_if.source  rsp
);

    walk_cmd_t              cmd;
    walk_sts_t              sts;
    table_wr_t              wr;
    logic [GROUP_IDX_W-1:0] rd_addr;
    table_entry_t           rd_entry;

    logic               accept;
    logic               load;
    logic [GROUP_W-1:0] sgrp;
    logic [GROUP_W-1:0] ogrp;
    logic [COMP_W-1:0]  scomp;
    logic [COMP_W-1:0]  ocomp;
    logic               lev_ok;
    logic               comp_ok;
    logic               grant;

    logic    lev_ok_reg, lev_ok_next;
    logic    comp_ok_reg, comp_ok_next;
    access_t access_reg, access_next;
    policy_t policy_reg, policy_next;
    logic    rsp_valid_reg, rsp_valid_next;
    logic    granted_reg, granted_next;
    logic    level_ok_reg, level_ok_next;
    logic    comps_ok_reg, comps_ok_next;
    logic    groups_ok_reg, groups_ok_next;

    assign req.ready = sts.idle;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        sgrp    = req.subject_groups & GROUP_MASK;
        ogrp    = req.object_groups & GROUP_MASK;
        scomp   = req.subject_compartments & COMP_MASK;
        ocomp   = req.object_compartments & COMP_MASK;
        lev_ok  = (access_t'(req.access_kind) == ACC_WRITE)
                  ? (req.subject_level == req.object_level)
                  : (req.subject_level >= req.object_level);
        comp_ok = ((ocomp & ~scomp) == '0);
    end

    // cases the mask test settles without a walk
    always_comb
    begin
        cmd.start = accept && (op_t'(req.operation) == OP_CHECK);
        cmd.subj  = sgrp;
        cmd.obj   = ogrp;
        cmd.quick = 1'b1;
        priority if (policy_t'(req.policy) == POL_COMP_ONLY)
        begin
            cmd.quick_ok = 1'b1;
        end
        else if (ogrp == '0)
        begin
            cmd.quick_ok = 1'b1;
        end
        else if (sgrp == '0)
        begin
            cmd.quick_ok = 1'b0;
        end
        else if ((sgrp & ogrp) != '0)
        begin
            cmd.quick_ok = 1'b1;
        end
        else
        begin
            cmd.quick    = 1'b0;
            cmd.quick_ok = 1'b0;
        end
    end

    always_comb
    begin
        wr.en               = accept && (op_t'(req.operation) == OP_SET_PARENT)
                              && (32'(req.group_index) < NUM_GROUPS);
        wr.idx              = req.group_index;
        wr.entry.parent     = req.parent_index;
        wr.entry.has_parent = req.parent_valid;
    end

    mlac_parent_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    mlac_walk_seq u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ack      (load),
        .sts      (sts),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        lev_ok_next  = lev_ok_reg;
        comp_ok_next = comp_ok_reg;
        access_next  = access_reg;
        policy_next  = policy_reg;
        if (cmd.start)
        begin
            lev_ok_next  = lev_ok;
            comp_ok_next = comp_ok;
            access_next  = access_t'(req.access_kind);
            policy_next  = policy_t'(req.policy);
        end
    end

    always_comb
    begin
        priority if (policy_reg == POL_FULL)
        begin
            grant = 1'b1;
        end
        else if (policy_reg == POL_READ && access_reg == ACC_READ)
        begin
            grant = 1'b1;
        end
        else
        begin
            grant = lev_ok_reg && comp_ok_reg && sts.groups_ok;
        end
    end

    // output register frees the sequencer as soon as the result is parked
    always_comb
    begin
        load           = sts.done && (!rsp_valid_reg || rsp.ready);
        rsp_valid_next = rsp_valid_reg;
        granted_next   = granted_reg;
        level_ok_next  = level_ok_reg;
        comps_ok_next  = comps_ok_reg;
        groups_ok_next = groups_ok_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
            granted_next   = grant;
            level_ok_next  = lev_ok_reg;
            comps_ok_next  = comp_ok_reg;
            groups_ok_next = sts.groups_ok;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lev_ok_reg    <= lev_ok_next;
        comp_ok_reg   <= comp_ok_next;
        access_reg    <= access_next;
        policy_reg    <= policy_next;
        granted_reg   <= granted_next;
        level_ok_reg  <= level_ok_next;
        comps_ok_reg  <= comps_ok_next;
        groups_ok_reg <= groups_ok_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted         = granted_reg;
    assign rsp.level_ok        = level_ok_reg;
    assign rsp.compartments_ok = comps_ok_reg;
    assign rsp.groups_ok       = groups_ok_reg;

endmodule

// ----- src/mlac_parent_table.sv -----
`timescale 1ns / 1ps

module mlac_parent_table
    import mlac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  table_wr_t              wr,
    input  logic [GROUP_IDX_W-1:0] rd_addr,
    output table_entry_t           rd_entry
);

    logic [GROUP_IDX_W-1:0] parent_reg     [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] has_parent_reg;

    // parent numbers only matter once the flag is set, so they need no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            parent_reg[wr.idx] <= wr.entry.parent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_parent_reg <= '0;
        end
        else if (wr.en)
        begin
            has_parent_reg[wr.idx] <= wr.entry.has_parent;
        end
    end

    assign rd_entry.has_parent = has_parent_reg[rd_addr];
    assign rd_entry.parent     = parent_reg[rd_addr];

endmodule

// ----- src/mlac_walk_seq.sv -----
`timescale 1ns / 1ps

module mlac_walk_seq
    import mlac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  walk_cmd_t              cmd,
    input  logic                   ack,
    output walk_sts_t              sts,
    output logic [GROUP_IDX_W-1:0] rd_addr,
    input  table_entry_t           rd_entry
);

    walk_state_t            state_reg, state_next;
    logic [GROUP_IDX_W-1:0] g_reg, g_next;
    logic [GROUP_IDX_W-1:0] cur_reg, cur_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [GROUP_W-1:0]     subj_reg, subj_next;
    logic [GROUP_W-1:0]     obj_reg, obj_next;
    logic                   ok_reg, ok_next;

    logic chain_end;
    logic hit;
    logic last_group;
    logic group_set;

    always_comb
    begin
        chain_end  = !rd_entry.has_parent || (32'(rd_entry.parent) >= NUM_GROUPS);
        hit        = !chain_end && subj_reg[rd_entry.parent];
        last_group = (g_reg == LAST_GROUP);
        group_set  = obj_reg[g_reg];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = cmd.quick ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (group_set)
                begin
                    state_next = ST_WALK;
                end
                else if (last_group)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_DONE;
                end
                else if (chain_end || step_reg == LAST_STEP)
                begin
                    state_next = last_group ? ST_DONE : ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        sts.idle      = (state_reg == ST_IDLE);
        sts.done      = (state_reg == ST_DONE);
        sts.groups_ok = ok_reg;
        rd_addr       = cur_reg;
    end

    // walk registers
    always_comb
    begin
        g_next    = g_reg;
        cur_next  = cur_reg;
        step_next = step_reg;
        subj_next = subj_reg;
        obj_next  = obj_reg;
        ok_next   = ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    subj_next = cmd.subj;
                    obj_next  = cmd.obj;
                    ok_next   = cmd.quick && cmd.quick_ok;
                    g_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (group_set)
                begin
                    cur_next  = g_reg;
                    step_next = '0;
                end
                else if (!last_group)
                begin
                    g_next = g_reg + 1'b1;
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    ok_next = 1'b1;
                end
                else if (chain_end || step_reg == LAST_STEP)
                begin
                    if (!last_group)
                    begin
                        g_next = g_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_next  = rd_entry.parent;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg    <= g_next;
        cur_reg  <= cur_next;
        step_reg <= step_next;
        subj_reg <= subj_next;
        obj_reg  <= obj_next;
        ok_reg   <= ok_next;
    end

endmodule

// ----- src/mlac_checker.sv -----
`timescale 1ns / 1ps

module mlac_checker
    import mlac_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_operation,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_granted,
    input logic rsp_level_ok,
    input logic rsp_compartments_ok,
    input logic rsp_groups_ok
);

    // a pending result is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    // a check request drops input ready in the cycle after its acceptance
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (op_t'(req_operation) == OP_CHECK) |=> !req_ready)
        else $error("input ready right after a check request");

    // a set-parent request never produces a result
    a_set_parent_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (op_t'(req_operation) == OP_SET_PARENT)
        |=> !$rose(rsp_valid))
        else $error("result appeared after a set-parent request");

    // all partial tests passing always grants
    a_grant_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_level_ok && rsp_compartments_ok && rsp_groups_ok |-> rsp_granted)
        else $error("access denied although every test passed");

endmodule

bind mac_label_access_check mlac_checker u_mlac_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_operation       (req.operation),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_granted         (rsp.granted),
    .rsp_level_ok        (rsp.level_ok),
    .rsp_compartments_ok (rsp.compartments_ok),
    .rsp_groups_ok       (rsp.groups_ok)
);
